FILE: hw/rtl/upe_pkg.sv
// Shared types, constants and helpers for the URL percent encoder.
package upe_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] LIM_ONE_BYTE = 16'h007F;
    localparam logic [15:0] LIM_TWO_BYTE = 16'h07FF;
    localparam logic [7:0]  LEAD_TWO     = 8'hC0;
    localparam logic [7:0]  LEAD_THREE   = 8'hE0;
    localparam logic [7:0]  CONT_MARK    = 8'h80;
    localparam logic [7:0]  CONT_MASK    = 8'h3F;

    localparam logic [7:0]  CH_PERCENT   = 8'h25;
    localparam logic [7:0]  CH_PLUS      = 8'h2B;
    localparam logic [7:0]  CH_SPACE     = 8'h20;

    // Classified code unit: either one literal character or 1 to 3 bytes to escape.
    typedef struct packed {
        logic            lit;
        logic [7:0]      lit_char;
        logic [1:0]      nbytes;
        logic [2:0][7:0] bytes;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + {4'd0, d};
        end else begin
            c = 8'h57 + {4'd0, d};
        end
        return c;
    endfunction

    function automatic logic passes_through(input logic [15:0] u);
        logic p;
        p = 1'b0;
        if (u[15:8] == 8'd0) begin
            case (u[7:0]) inside
                [8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29:
                    p = 1'b1;
                default: p = 1'b0;
            endcase
        end
        return p;
    endfunction

endpackage

FILE: hw/rtl/upe_front.sv
// Front end: classifies one code unit into a literal or a UTF-8 byte list.
module upe_front (
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [15:0]   i_code_unit,
    output logic          o_push,
    output upe_pkg::t_desc o_desc,
    input  upe_pkg::t_q_stat i_q_stat
);
    import upe_pkg::*;

    logic [15:0] u;

    assign u       = i_code_unit;
    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    always_comb begin
        o_desc          = '0;
        o_desc.lit_char = u[7:0];
        if (passes_through(u)) begin
            o_desc.lit = 1'b1;
        end else if (u == {8'd0, CH_SPACE}) begin
            o_desc.lit      = 1'b1;
            o_desc.lit_char = CH_PLUS;
        end else if (u <= LIM_ONE_BYTE) begin
            o_desc.nbytes   = 2'd1;
            o_desc.bytes[0] = u[7:0];
        end else if (u <= LIM_TWO_BYTE) begin
            o_desc.nbytes   = 2'd2;
            o_desc.bytes[0] = LEAD_TWO | {3'd0, u[10:6]};
            o_desc.bytes[1] = CONT_MARK | ({2'd0, u[5:0]} & CONT_MASK);
        end else begin
            o_desc.nbytes   = 2'd3;
            o_desc.bytes[0] = LEAD_THREE | {4'd0, u[15:12]};
            o_desc.bytes[1] = CONT_MARK | ({2'd0, u[11:6]} & CONT_MASK);
            o_desc.bytes[2] = CONT_MARK | ({2'd0, u[5:0]} & CONT_MASK);
        end
    end

endmodule

FILE: hw/rtl/upe_queue.sv
// Short queue of classified words between the front and the back end.
module upe_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  upe_pkg::t_desc    i_desc,
    input  logic              i_pop,
    output upe_pkg::t_desc    o_desc,
    output logic              o_valid,
    output upe_pkg::t_q_stat  o_stat
);
    import upe_pkg::*;

    t_desc           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, n_wptr;
    logic [Q_AW-1:0] r_rptr, n_rptr;
    logic [Q_CW-1:0] r_count, n_count;
    logic            do_pop;

    assign do_pop       = i_pop && (r_count != '0);
    assign o_valid      = (r_count != '0);
    assign o_desc       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

endmodule

FILE: hw/rtl/upe_back.sv
// Back end: walks the head word one character per cycle into the output register while i_ready lets it.
module upe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  upe_pkg::t_desc i_desc,
    input  logic           i_desc_valid,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_char,
    output logic           o_last
);
    import upe_pkg::*;

    localparam logic [1:0] PH_PCT = 2'd0;
    localparam logic [1:0] PH_HI  = 2'd1;
    localparam logic [1:0] PH_LO  = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [1:0] r_byte, n_byte;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;
    logic       emit;
    logic [7:0] cur_byte;
    logic [7:0] ch;
    logic       ch_last;

    assign emit     = i_desc_valid && (!r_out_valid || i_ready);
    assign cur_byte = i_desc.bytes[r_byte];

    always_comb begin
        ch      = CH_PERCENT;
        ch_last = 1'b0;
        if (i_desc.lit) begin
            ch      = i_desc.lit_char;
            ch_last = 1'b1;
        end else begin
            unique case (r_phase)
                PH_PCT:  ch = CH_PERCENT;
                PH_HI:   ch = hex_char(cur_byte[7:4]);
                PH_LO: begin
                    ch      = hex_char(cur_byte[3:0]);
                    ch_last = (r_byte == i_desc.nbytes - 2'd1);
                end
                default: ch = CH_PERCENT;
            endcase
        end
    end

    assign o_pop = emit && ch_last;

    always_comb begin
        n_phase = r_phase;
        n_byte  = r_byte;
        if (emit) begin
            if (ch_last) begin
                n_phase = PH_PCT;
                n_byte  = '0;
            end else if (r_phase == PH_LO) begin
                n_phase = PH_PCT;
                n_byte  = r_byte + 2'd1;
            end else begin
                n_phase = r_phase + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PCT;
            r_byte      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_byte  <= n_byte;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char <= ch;
            r_out_last <= ch_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_last     = r_out_last;

endmodule

FILE: hw/rtl/url_percent_encoder_utf8.sv
// Top level of the URL percent encoder for UTF-16 code units.
// The input channel (i_valid, o_ready, i_code_unit) takes one 16-bit code unit
// per word. The output channel (o_valid, i_ready, o_out_char, o_last) gives the
// encoded text one ASCII character per word, with o_last high on the final
// character of each code unit.
// A code unit yields one character when it passes through or is a space, and
// three, six or nine characters when it is escaped as one, two or three UTF-8
// bytes. When the block is empty, an accepted code unit is written into the queue,
// and its first character is then written into the output register.
// The output runs at one character per cycle while i_ready is high, and a
// two-word queue lets new code units be taken while earlier ones are still
// being written out.
// When the receiver holds i_ready low, the current character stays in the
// output register, the sequencer waits, and o_ready falls once the queue fills.
// Reset empties the queue and the output register and clears the sequencer's phase and byte index.
module url_percent_encoder_utf8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_code_unit,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_char,
    output logic        o_last
);
    import upe_pkg::*;

    t_desc   f_desc;
    t_desc   q_desc;
    logic    f_push;
    logic    q_valid;
    logic    b_pop;
    t_q_stat q_stat;

    upe_front u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_code_unit (i_code_unit),
        .o_push      (f_push),
        .o_desc      (f_desc),
        .i_q_stat    (q_stat)
    );

    upe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_desc  (f_desc),
        .i_pop   (b_pop),
        .o_desc  (q_desc),
        .o_valid (q_valid),
        .o_stat  (q_stat)
    );

    upe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (q_desc),
        .i_desc_valid (q_valid),
        .o_pop        (b_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_char   (o_out_char),
        .o_last       (o_last)
    );

    a_pct_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_char == CH_PERCENT) |-> !o_last)
        else $error("percent sign marked as last character");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !o_ready)
        else $error("input ready while queue is full");

    a_first_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && q_stat.empty && !o_valid) |-> ##2 o_valid)
        else $error("first character did not appear two cycles after accept");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_pop |-> (q_valid && !q_stat.empty))
        else $error("queue popped while empty");

endmodule

FILE: tb/tb_url_percent_encoder_utf8.sv
// Self-checking testbench for the URL percent encoder with its own prediction of the encoded text.
module tb_url_percent_encoder_utf8;
    timeunit 1ns;
    timeprecision 1ps;

    import upe_pkg::*;

    localparam int RANDOM_UNITS = 85;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [8:0][7:0] MARK_CHARS = {
        8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29
    };

    typedef struct packed {
        logic [7:0] ascii;
        logic       last;
    } enc_char_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_code_unit = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_char;
    logic        o_last;

    int          cycle_count = 0;
    int          ready_mode = 0;
    int          ready_left = 0;
    logic [15:0] stimulus_units[$];

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = 8'h30 + {4'd0, n};
        end else begin
            c = 8'h61 + {4'd0, n} - 8'd10;
        end
        return c;
    endfunction

    function automatic logic is_unreserved(input logic [15:0] u);
        return u inside {[16'h0041:16'h005A], [16'h0061:16'h007A], [16'h0030:16'h0039],
                         16'h002D, 16'h005F, 16'h002E, 16'h0021, 16'h007E,
                         16'h002A, 16'h0027, 16'h0028, 16'h0029};
    endfunction

    class encoded_text_board;
        enc_char_t pending_chars[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void push_char(input logic [7:0] c);
            enc_char_t e;
            e.ascii = c;
            e.last  = 1'b0;
            pending_chars.push_back(e);
        endfunction

        function void push_escaped(input logic [7:0] b);
            push_char(CH_PERCENT);
            push_char(nibble_char(b[7:4]));
            push_char(nibble_char(b[3:0]));
        endfunction

        function void note_code_unit(input logic [15:0] u);
            if (is_unreserved(u)) begin
                push_char(u[7:0]);
            end else if (u == {8'd0, CH_SPACE}) begin
                push_char(CH_PLUS);
            end else if (u <= LIM_ONE_BYTE) begin
                push_escaped(u[7:0]);
            end else if (u <= LIM_TWO_BYTE) begin
                push_escaped(LEAD_TWO | {3'd0, u[10:6]});
                push_escaped(CONT_MARK | ({2'd0, u[5:0]} & CONT_MASK));
            end else begin
                push_escaped(LEAD_THREE | {4'd0, u[15:12]});
                push_escaped(CONT_MARK | ({2'd0, u[11:6]} & CONT_MASK));
                push_escaped(CONT_MARK | ({2'd0, u[5:0]} & CONT_MASK));
            end
            pending_chars[pending_chars.size() - 1].last = 1'b1;
        endfunction

        function void check_char(input logic [7:0] c, input logic l);
            enc_char_t e;
            if (pending_chars.size() == 0) begin
                $error("unexpected word: out_char %h last %b", c, l);
                mismatches++;
                return;
            end
            e = pending_chars.pop_front();
            if (c !== e.ascii) begin
                $error("out_char: expected %h, actual %h", e.ascii, c);
                mismatches++;
            end
            if (l !== e.last) begin
                $error("last: expected %b, actual %b", e.last, l);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction
    endclass

    encoded_text_board board;

    url_percent_encoder_utf8 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_code_unit (i_code_unit),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            board.note_code_unit(i_code_unit);
        end
        if (i_rst_n && o_valid && i_ready) begin
            board.check_char(o_out_char, o_last);
        end
    end

    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(4, 40);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= (ready_left % 16 == 0);
        endcase
    end

    function automatic logic [15:0] pick_code_unit();
        logic [15:0] u;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                case ($urandom_range(0, 3))
                    0: u = 16'($urandom_range(16'h0041, 16'h005A));
                    1: u = 16'($urandom_range(16'h0061, 16'h007A));
                    2: u = 16'($urandom_range(16'h0030, 16'h0039));
                    default: u = {8'd0, MARK_CHARS[$urandom_range(0, 8)]};
                endcase
            end
            3: u = {8'd0, CH_SPACE};
            4, 5: u = 16'($urandom_range(16'h0000, 16'h007F));
            6, 7: u = 16'($urandom_range(16'h0080, 16'h07FF));
            default: u = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        return u;
    endfunction

    task automatic send_unit(input logic [15:0] u);
        i_valid     <= 1'b1;
        i_code_unit <= u;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic pause_sender(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_sender();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic play_units();
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 8);
        while (stimulus_units.size() != 0) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    pause_sender(gap);
                end
                burst_left = $urandom_range(1, 8);
            end
            send_unit(stimulus_units.pop_front());
            burst_left--;
        end
    endtask

    task automatic load_random(input int count);
        repeat (count) stimulus_units.push_back(pick_code_unit());
    endtask

    initial begin
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        stimulus_units = '{16'h0000, 16'hFFFF, 16'h0041, 16'h005A, 16'h0061, 16'h007A,
                           16'h0030, 16'h0039, 16'h002D, 16'h005F, 16'h002E, 16'h0021,
                           16'h007E, 16'h002A, 16'h0027, 16'h0028, 16'h0029, 16'h0020,
                           16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD800, 16'hDFFF,
                           16'h0141};
        play_units();
        drain_sender();

        load_random(RANDOM_UNITS / 2);
        play_units();
        drain_sender();
        load_random(RANDOM_UNITS - RANDOM_UNITS / 2);
        play_units();
        drain_sender();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
